### rtl/core/jst_pkg.sv
// shared types and constants for the job slot table
// no dependencies; used by every module of the block by scoped names
`default_nettype none

package jst_pkg;

   // field widths of the item channels
   localparam int unsigned CMD_W    = 2;
   localparam int unsigned PID_W    = 22;
   localparam int unsigned STATE_W  = 2;
   localparam int unsigned NUM_W    = 5;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned REQ_W    = 32;
   localparam int unsigned RSP_W    = 16;

   // commands
   typedef enum logic [CMD_W-1:0] {
      CMD_ADD    = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_UPDATE = 2'd2,
      CMD_LOOKUP = 2'd3
   } cmd_type;

   // slot states
   typedef enum logic [STATE_W-1:0] {
      ST_FREE       = 2'd0,
      ST_RUNNING    = 2'd1,
      ST_FOREGROUND = 2'd2,
      ST_SUSPENDED  = 2'd3
   } slot_state_type;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      RES_OK      = 2'd0,
      RES_FULL    = 2'd1,
      RES_MISSING = 2'd2
   } status_type;

   // sequencer states
   typedef enum logic [1:0] {
      FSM_IDLE   = 2'd0,
      FSM_SCAN   = 2'd1,
      FSM_DRAIN  = 2'd2,
      FSM_RESULT = 2'd3
   } fsm_type;

endpackage

`default_nettype wire

### rtl/core/jst_pid_ram.sv
// pid memory of the job slot table: one write port, one registered read port
// depends on jst_pkg for the pid width
`default_nettype none

module jst_pid_ram #(
   parameter int unsigned SLOT_COUNT = 16,
   parameter int unsigned IDX_W      = 4
) (
   input  wire logic                          clock,
   input  wire logic                          wr_en,
   input  wire logic [IDX_W-1:0]              wr_idx,
   input  wire logic [jst_pkg::PID_W-1:0]     wr_pid,
   input  wire logic [IDX_W-1:0]              rd_idx,
   output logic      [jst_pkg::PID_W-1:0]     rd_pid
);

   logic [jst_pkg::PID_W-1:0] pid_mem_ff [SLOT_COUNT];
   logic [jst_pkg::PID_W-1:0] rd_pid_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         pid_mem_ff[wr_idx] <= wr_pid;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_pid_ff <= pid_mem_ff[rd_idx];
   end

   assign rd_pid = rd_pid_ff;

endmodule

`default_nettype wire

### rtl/core/jst_state_file.sv
// per-slot state registers of the job slot table, cleared to free on reset
// depends on jst_pkg for the slot state type
`default_nettype none

module jst_state_file #(
   parameter int unsigned SLOT_COUNT = 16,
   parameter int unsigned IDX_W      = 4
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        wr_en,
   input  wire logic [IDX_W-1:0]            wr_idx,
   input  wire jst_pkg::slot_state_type     wr_state,
   input  wire logic [IDX_W-1:0]            rd_idx,
   output jst_pkg::slot_state_type          rd_state
);

   jst_pkg::slot_state_type state_ff [SLOT_COUNT];
   jst_pkg::slot_state_type state_in [SLOT_COUNT];

   // next state of each slot
   always_comb begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
         state_in[i] = state_ff[i];
      end
      if (wr_en) begin
         state_in[wr_idx] = wr_state;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (reset) begin
            state_ff[i] <= jst_pkg::ST_FREE;
         end else begin
            state_ff[i] <= state_in[i];
         end
      end
   end

   // read at the slot under compare
   assign rd_state = state_ff[rd_idx];

endmodule

`default_nettype wire

### rtl/core/job_slot_table.sv
// job slot table: add, remove, update and lookup over a fixed table of slots
// items: one at a time, a new item is accepted only once the last result is in the output register
// scan: reads one slot per cycle through the single read port of the pid memory and one
//   compare unit
// reset: synchronous, clears all slot states to free and the handshake state;
//   the pid memory is not cleared, a free slot's pid is never matched
`default_nettype none

module job_slot_table #(
   parameter int unsigned SLOT_COUNT = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // req_tdata: command[1:0], pid[23:2], new_state[25:24], job_number[30:26]
   input  wire logic [jst_pkg::REQ_W-1:0]     req_tdata,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   // rsp_tdata: status[1:0], found_number[6:2], foreground_number[11:7]
   output logic      [jst_pkg::RSP_W-1:0]     rsp_tdata,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready
);

   localparam int unsigned IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int unsigned CNT_W  = $clog2(SLOT_COUNT + 1);
   localparam int unsigned CMP_W  = (CNT_W > jst_pkg::NUM_W) ? CNT_W : jst_pkg::NUM_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

   // sequencer and scan registers
   jst_pkg::fsm_type fsm_ff, fsm_in;
   logic [IDX_W-1:0] addr_ff, addr_in;
   logic             cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0] cmp_idx_ff;
   logic             hit_seen_ff, hit_seen_in;
   logic [jst_pkg::NUM_W-1:0] hit_num_ff, hit_num_in;
   logic             fg_seen_ff, fg_seen_in;
   logic [jst_pkg::NUM_W-1:0] fg_num_ff, fg_num_in;

   // latched request fields
   jst_pkg::cmd_type          cmd_ff;
   logic [jst_pkg::PID_W-1:0] pid_ff;
   jst_pkg::slot_state_type   new_st_ff;
   logic [jst_pkg::NUM_W-1:0] num_ff;

   // output register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [jst_pkg::RSP_W-1:0] rsp_data_ff, rsp_data_in;

   logic req_accept;
   logic load_rsp;

   // compare unit signals
   jst_pkg::slot_state_type   cur_st;
   jst_pkg::slot_state_type   eff_st;
   logic [jst_pkg::PID_W-1:0] ram_pid;
   logic [CMP_W-1:0]          slot_no;
   logic                      occupied;
   logic                      pid_eq;
   logic                      hit;
   logic                      first;
   logic                      st_wr_en;
   jst_pkg::slot_state_type   st_wr_val;
   logic                      pid_wr_en;
   logic [jst_pkg::PID_W-1:0] pid_wr_val;
   jst_pkg::status_type       res_status;
   logic [jst_pkg::NUM_W-1:0] res_found;

   assign req_tready = (fsm_ff == jst_pkg::FSM_IDLE);
   assign req_accept = req_tvalid && req_tready;

   // storage
   jst_pid_ram #(
      .SLOT_COUNT (SLOT_COUNT),
      .IDX_W      (IDX_W)
   ) u_pid_ram (
      .clock  (clock),
      .wr_en  (pid_wr_en),
      .wr_idx (cmp_idx_ff),
      .wr_pid (pid_wr_val),
      .rd_idx (addr_ff),
      .rd_pid (ram_pid)
   );

   jst_state_file #(
      .SLOT_COUNT (SLOT_COUNT),
      .IDX_W      (IDX_W)
   ) u_state_file (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (st_wr_en),
      .wr_idx   (cmp_idx_ff),
      .wr_state (st_wr_val),
      .rd_idx   (cmp_idx_ff),
      .rd_state (cur_st)
   );

   // compare unit: one slot per cycle, modified slot is always the first hit
   always_comb begin
      occupied = (cur_st != jst_pkg::ST_FREE);
      pid_eq   = (ram_pid == pid_ff);
      slot_no  = CMP_W'(cmp_idx_ff) + CMP_W'(1);
      case (cmd_ff)
         jst_pkg::CMD_ADD:    hit = !occupied;
         jst_pkg::CMD_REMOVE: hit = occupied && (slot_no == CMP_W'(num_ff));
         default:             hit = occupied && pid_eq;
      endcase
      first = cmp_vld_ff && hit && !hit_seen_ff;

      // state of this slot after the command
      eff_st = cur_st;
      case (cmd_ff)
         jst_pkg::CMD_ADD, jst_pkg::CMD_UPDATE: begin
            if (first) eff_st = new_st_ff;
         end
         jst_pkg::CMD_REMOVE: begin
            if (first) eff_st = jst_pkg::ST_FREE;
         end
         default: eff_st = cur_st;
      endcase

      st_wr_en   = first && (cmd_ff != jst_pkg::CMD_LOOKUP);
      st_wr_val  = eff_st;
      pid_wr_en  = first && (cmd_ff == jst_pkg::CMD_ADD || cmd_ff == jst_pkg::CMD_REMOVE);
      pid_wr_val = (cmd_ff == jst_pkg::CMD_REMOVE) ? '0 : pid_ff;
   end

   // result fields
   always_comb begin
      if (hit_seen_ff) begin
         res_status = jst_pkg::RES_OK;
      end else if (cmd_ff == jst_pkg::CMD_ADD) begin
         res_status = jst_pkg::RES_FULL;
      end else begin
         res_status = jst_pkg::RES_MISSING;
      end
      if (hit_seen_ff && (cmd_ff == jst_pkg::CMD_ADD || cmd_ff == jst_pkg::CMD_LOOKUP)) begin
         res_found = hit_num_ff;
      end else begin
         res_found = '0;
      end
   end

   // sequencer next state and scan bookkeeping
   always_comb begin
      fsm_in      = fsm_ff;
      addr_in     = addr_ff;
      cmp_vld_in  = 1'b0;
      hit_seen_in = hit_seen_ff;
      hit_num_in  = hit_num_ff;
      fg_seen_in  = fg_seen_ff;
      fg_num_in   = fg_num_ff;
      load_rsp    = 1'b0;

      if (first) begin
         hit_seen_in = 1'b1;
         hit_num_in  = slot_no[jst_pkg::NUM_W-1:0];
      end
      if (cmp_vld_ff && eff_st == jst_pkg::ST_FOREGROUND && !fg_seen_ff) begin
         fg_seen_in = 1'b1;
         fg_num_in  = slot_no[jst_pkg::NUM_W-1:0];
      end

      case (fsm_ff)
         jst_pkg::FSM_IDLE: begin
            if (req_accept) begin
               fsm_in      = jst_pkg::FSM_SCAN;
               addr_in     = '0;
               hit_seen_in = 1'b0;
               fg_seen_in  = 1'b0;
               fg_num_in   = '0;
            end
         end
         jst_pkg::FSM_SCAN: begin
            cmp_vld_in = 1'b1;
            if (addr_ff == LAST_IDX) begin
               fsm_in = jst_pkg::FSM_DRAIN;
            end else begin
               addr_in = addr_ff + IDX_W'(1);
            end
         end
         jst_pkg::FSM_DRAIN: begin
            fsm_in = jst_pkg::FSM_RESULT;
         end
         jst_pkg::FSM_RESULT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               load_rsp = 1'b1;
               fsm_in   = jst_pkg::FSM_IDLE;
            end
         end
         default: fsm_in = jst_pkg::FSM_IDLE;
      endcase
   end

   // output register next value
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {4'b0000, fg_num_ff, res_found, res_status};
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff       <= jst_pkg::FSM_IDLE;
         cmp_vld_ff   <= 1'b0;
         hit_seen_ff  <= 1'b0;
         fg_seen_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fsm_ff       <= fsm_in;
         cmp_vld_ff   <= cmp_vld_in;
         hit_seen_ff  <= hit_seen_in;
         fg_seen_ff   <= fg_seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      addr_ff     <= addr_in;
      cmp_idx_ff  <= addr_ff;
      hit_num_ff  <= hit_num_in;
      fg_num_ff   <= fg_num_in;
      rsp_data_ff <= rsp_data_in;
      if (req_accept) begin
         cmd_ff    <= jst_pkg::cmd_type'(req_tdata[1:0]);
         pid_ff    <= req_tdata[23:2];
         new_st_ff <= jst_pkg::slot_state_type'(req_tdata[25:24]);
         num_ff    <= req_tdata[30:26];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// testbench for job_slot_table: directed table then random add, remove, update, lookup items
// depends on jst_pkg for field widths and codes, and on the job_slot_table top level

module testbench;

   localparam int unsigned SLOTS       = 16;
   localparam int unsigned LATENCY     = SLOTS + 3;
   localparam int unsigned RANDOM_ITEMS = 450;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned POOL_SIZE   = 6;

   // one result item as the predictor sees it
   typedef struct packed {
      jst_pkg::status_type     status;
      logic [4:0]              found;
      logic [4:0]              fg;
   } job_result_type;

   // one stimulus row; typed rows carry their own expected result
   typedef struct packed {
      jst_pkg::cmd_type        cmd;
      logic [21:0]             pid;
      jst_pkg::slot_state_type st;
      logic [4:0]              num;
      logic                    typed;
      job_result_type          res;
   } stim_row_type;

   localparam job_result_type NO_RES = '{jst_pkg::RES_OK, 5'd0, 5'd0};

   localparam stim_row_type DIRECTED [29] = '{
      // empty table: nothing matches, free slots are never matched
      '{jst_pkg::CMD_LOOKUP, 22'h000000, jst_pkg::ST_FREE, 5'd0, 1'b1,
        '{jst_pkg::RES_MISSING, 5'd0, 5'd0}},
      '{jst_pkg::CMD_REMOVE, 22'h000000, jst_pkg::ST_FREE, 5'd0, 1'b1,
        '{jst_pkg::RES_MISSING, 5'd0, 5'd0}},
      '{jst_pkg::CMD_REMOVE, 22'h3fffff, jst_pkg::ST_SUSPENDED, 5'd1, 1'b1,
        '{jst_pkg::RES_MISSING, 5'd0, 5'd0}},
      '{jst_pkg::CMD_REMOVE, 22'h000000, jst_pkg::ST_RUNNING, 5'd31, 1'b1,
        '{jst_pkg::RES_MISSING, 5'd0, 5'd0}},
      '{jst_pkg::CMD_UPDATE, 22'h000000, jst_pkg::ST_RUNNING, 5'd0, 1'b1,
        '{jst_pkg::RES_MISSING, 5'd0, 5'd0}},
      // first adds, one with a free state that leaves its slot open
      '{jst_pkg::CMD_ADD, 22'h3fffff, jst_pkg::ST_RUNNING, 5'd31, 1'b1,
        '{jst_pkg::RES_OK, 5'd1, 5'd0}},
      '{jst_pkg::CMD_ADD, 22'h000000, jst_pkg::ST_FREE, 5'd0, 1'b1,
        '{jst_pkg::RES_OK, 5'd2, 5'd0}},
      '{jst_pkg::CMD_ADD, 22'h000005, jst_pkg::ST_FOREGROUND, 5'd16, 1'b1,
        '{jst_pkg::RES_OK, 5'd2, 5'd2}},
      '{jst_pkg::CMD_LOOKUP, 22'h3fffff, jst_pkg::ST_FREE, 5'd0, 1'b1,
        '{jst_pkg::RES_OK, 5'd1, 5'd2}},
      '{jst_pkg::CMD_UPDATE, 22'h000005, jst_pkg::ST_SUSPENDED, 5'd7, 1'b0, NO_RES},
      // fill the rest of the table, a duplicate pid among them
      '{jst_pkg::CMD_ADD, 22'h3fffff, jst_pkg::ST_RUNNING, 5'd0, 1'b0, NO_RES},
      '{jst_pkg::CMD_ADD, 22'h2aaaaa, jst_pkg::ST_FOREGROUND, 5'd21, 1'b0, NO_RES},
      '{jst_pkg::CMD_ADD, 22'h155555, jst_pkg::ST_SUSPENDED, 5'd10, 1'b0, NO_RES},
      '{jst_pkg::CMD_ADD, 22'h000001, jst_pkg::ST_RUNNING, 5'd0, 1'b0, NO_RES},
      '{jst_pkg::CMD_ADD, 22'h200000, jst_pkg::ST_FOREGROUND, 5'd0, 1'b0, NO_RES},
      '{jst_pkg::CMD_ADD, 22'h0fffff, jst_pkg::ST_SUSPENDED, 5'd0, 1'b0, NO_RES},
      '{jst_pkg::CMD_ADD, 22'h000000, jst_pkg::ST_RUNNING, 5'd0, 1'b0, NO_RES},
      '{jst_pkg::CMD_ADD, 22'h111111, jst_pkg::ST_RUNNING, 5'd0, 1'b0, NO_RES},
      '{jst_pkg::CMD_ADD, 22'h222222, jst_pkg::ST_SUSPENDED, 5'd0, 1'b0, NO_RES},
      '{jst_pkg::CMD_ADD, 22'h333333, jst_pkg::ST_FOREGROUND, 5'd0, 1'b0, NO_RES},
      '{jst_pkg::CMD_ADD, 22'h1fffff, jst_pkg::ST_RUNNING, 5'd0, 1'b0, NO_RES},
      '{jst_pkg::CMD_ADD, 22'h3c3c3c, jst_pkg::ST_SUSPENDED, 5'd0, 1'b0, NO_RES},
      '{jst_pkg::CMD_ADD, 22'h0f0f0f, jst_pkg::ST_RUNNING, 5'd0, 1'b0, NO_RES},
      '{jst_pkg::CMD_ADD, 22'h123456, jst_pkg::ST_FOREGROUND, 5'd0, 1'b0, NO_RES},
      // full table, lowest match, last slot, release by update
      '{jst_pkg::CMD_ADD, 22'h3abcde, jst_pkg::ST_RUNNING, 5'd0, 1'b0, NO_RES},
      '{jst_pkg::CMD_LOOKUP, 22'h3fffff, jst_pkg::ST_FREE, 5'd0, 1'b0, NO_RES},
      '{jst_pkg::CMD_REMOVE, 22'h000000, jst_pkg::ST_FREE, 5'd16, 1'b0, NO_RES},
      '{jst_pkg::CMD_UPDATE, 22'h3fffff, jst_pkg::ST_FREE, 5'd0, 1'b0, NO_RES},
      '{jst_pkg::CMD_LOOKUP, 22'h3fffff, jst_pkg::ST_FREE, 5'd0, 1'b0, NO_RES}
   };

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic [jst_pkg::REQ_W-1:0]   req_tdata = '0;
   logic                        req_tvalid = 1'b0;
   logic                        req_tready;
   logic [jst_pkg::RSP_W-1:0]   rsp_tdata;
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b0;

   // predictor copy of the slot table
   logic [21:0]                 tbl_pid [SLOTS];
   jst_pkg::slot_state_type     tbl_state [SLOTS];

   job_result_type              result_q [$];
   stim_row_type                issued_q [$];
   int unsigned                 errors = 0;
   int unsigned                 cycles = 0;
   bit                          tx_calm = 1'b0;
   bit                          rx_calm = 1'b0;
   logic [21:0]                 pid_pool [POOL_SIZE];

   job_slot_table #(.SLOT_COUNT(SLOTS)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),   // command, pid, new_state, job_number from bit 0 up
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),   // status, found_number, foreground_number from bit 0 up
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   // clock
   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      for (int i = 0; i < SLOTS; i++) begin
         tbl_pid[i]   = '0;
         tbl_state[i] = jst_pkg::ST_FREE;
      end
   end

   // lowest occupied slot holding this pid, SLOTS when none
   function automatic int unsigned match_slot(input logic [21:0] pid);
      for (int i = 0; i < SLOTS; i++) begin
         if (tbl_state[i] != jst_pkg::ST_FREE && tbl_pid[i] == pid) return i;
      end
      return SLOTS;
   endfunction

   // carry out one command on the predictor table
   task automatic apply_job_command(input jst_pkg::cmd_type cmd, input logic [21:0] pid,
                                    input jst_pkg::slot_state_type st,
                                    input logic [4:0] num,
                                    output job_result_type res);
      int unsigned slot;
      res = NO_RES;
      slot = SLOTS;
      case (cmd)
         jst_pkg::CMD_ADD: begin
            for (int i = SLOTS - 1; i >= 0; i--) begin
               if (tbl_state[i] == jst_pkg::ST_FREE) slot = i;
            end
            if (slot == SLOTS) begin
               res.status = jst_pkg::RES_FULL;
            end else begin
               tbl_pid[slot]   = pid;
               tbl_state[slot] = st;
               res.found       = 5'(slot + 1);
            end
         end
         jst_pkg::CMD_REMOVE: begin
            res.status = jst_pkg::RES_MISSING;
            if (num >= 1 && num <= SLOTS) begin
               if (tbl_state[num - 1] != jst_pkg::ST_FREE) begin
                  tbl_state[num - 1] = jst_pkg::ST_FREE;
                  tbl_pid[num - 1]   = '0;
                  res.status         = jst_pkg::RES_OK;
               end
            end
         end
         jst_pkg::CMD_UPDATE: begin
            slot = match_slot(pid);
            if (slot == SLOTS) res.status = jst_pkg::RES_MISSING;
            else tbl_state[slot] = st;
         end
         default: begin
            slot = match_slot(pid);
            if (slot == SLOTS) res.status = jst_pkg::RES_MISSING;
            else res.found = 5'(slot + 1);
         end
      endcase
      // first foreground job after the command
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (tbl_state[i] == jst_pkg::ST_FOREGROUND) res.fg = 5'(i + 1);
      end
   endtask

   // gap length: mostly none or short, now and then long
   function automatic int unsigned idle_len(input bit calm);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm || r < 50) return 0;
      if (r < 92) return $urandom_range(1, 4);
      return $urandom_range(15, 60);
   endfunction

   // put one item on the request channel and wait for its handshake
   task automatic send_item(input stim_row_type row);
      req_tdata  <= {1'b0, row.num, row.st, row.pid, row.cmd};
      req_tvalid <= 1'b1;
      issued_q.push_back(row);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic pause_sender(input int unsigned n);
      if (n != 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // random item, mostly on a small pool of pids so that matches happen
   function automatic stim_row_type random_row();
      stim_row_type row;
      int unsigned  r;
      row = '0;
      r = $urandom_range(0, 99);
      if (r < 35) row.cmd = jst_pkg::CMD_ADD;
      else if (r < 60) row.cmd = jst_pkg::CMD_REMOVE;
      else if (r < 80) row.cmd = jst_pkg::CMD_UPDATE;
      else row.cmd = jst_pkg::CMD_LOOKUP;
      if ($urandom_range(0, 4) != 0) row.pid = pid_pool[$urandom_range(0, POOL_SIZE - 1)];
      else row.pid = 22'($urandom);
      if (row.cmd == jst_pkg::CMD_ADD && $urandom_range(0, 9) != 0)
         row.st = jst_pkg::slot_state_type'($urandom_range(1, 3));
      else
         row.st = jst_pkg::slot_state_type'($urandom_range(0, 3));
      if (row.cmd == jst_pkg::CMD_REMOVE && $urandom_range(0, 99) < 85)
         row.num = 5'($urandom_range(1, SLOTS));
      else
         row.num = 5'($urandom_range(0, 31));
      return row;
   endfunction

   // reset, then stimulus, then drain and verdict
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      pid_pool[0] = 22'h000000;
      pid_pool[1] = 22'h3fffff;
      for (int i = 2; i < POOL_SIZE; i++) pid_pool[i] = 22'($urandom);

      foreach (DIRECTED[i]) begin
         send_item(DIRECTED[i]);
         pause_sender(idle_len(1'b0));
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 50 == 0) begin
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
         end
         send_item(random_row());
         // hold off until the table has answered everything
         if (n == RANDOM_ITEMS / 2) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (result_q.size() != 0 || issued_q.size() != 0) @(posedge clock);
         end else begin
            pause_sender(idle_len(tx_calm));
         end
      end

      req_tvalid <= 1'b0;
      while (result_q.size() != 0 || issued_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);
      if (errors == 0) begin
         $display("PASS job_slot_table");
      end else begin
         $display("FAIL job_slot_table");
      end
      $finish;
   end

   // result channel backpressure
   initial begin
      forever begin
         @(posedge clock);
         if (rx_calm || $urandom_range(0, 3) != 0) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b0;
            repeat (idle_len(1'b0) + 1) @(posedge clock);
            rsp_tready <= 1'b1;
         end
      end
   end

   // check result items, then predict newly accepted items
   always @(posedge clock) begin : monitor
      job_result_type want;
      job_result_type pred;
      stim_row_type   row;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (result_q.size() == 0) begin
               $error("result item with nothing pending: %h", rsp_tdata);
               errors++;
            end else begin
               want = result_q.pop_front();
               if (rsp_tdata[1:0] != want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_tdata[1:0]);
                  errors++;
               end
               if (rsp_tdata[6:2] != want.found) begin
                  $error("found_number: expected %0d, got %0d", want.found, rsp_tdata[6:2]);
                  errors++;
               end
               if (rsp_tdata[11:7] != want.fg) begin
                  $error("foreground_number: expected %0d, got %0d",
                         want.fg, rsp_tdata[11:7]);
                  errors++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            apply_job_command(jst_pkg::cmd_type'(req_tdata[1:0]), req_tdata[23:2],
                              jst_pkg::slot_state_type'(req_tdata[25:24]),
                              req_tdata[30:26], pred);
            row = issued_q.pop_front();
            result_q.push_back(row.typed ? row.res : pred);
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL job_slot_table");
         $finish;
      end
   end

endmodule
